// ===== src/asq_pkg.sv =====
// Shared types and constants for the abelian square stream detector.
// Used by the top level and the port checker.
package asq_pkg;

   localparam int MAX_PERIOD_LIMIT_DEFAULT = 64;
   localparam int LANE_W     = 8;
   localparam int NUM_LANES  = 3;
   localparam int COUNT_W    = LANE_W * NUM_LANES;
   localparam int PERIOD_W   = 7;
   localparam int SYMBOL_W   = 2;
   localparam int FIRST_PERIOD = 2;

   localparam logic [PERIOD_W-1:0] MAX_PERIOD_RESET = 7'd40;
   localparam logic [SYMBOL_W-1:0] SYM_NONE         = 2'd3;

   typedef struct packed {
      logic [SYMBOL_W-1:0] symbol;
      logic                restart;
   } req_payload_type;

   typedef struct packed {
      logic                square_ends_here;
      logic [PERIOD_W-1:0] square_period;
      logic                word_has_square;
   } rsp_payload_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_UPDATE,
      ST_SCAN,
      ST_FINISH
   } state_type;

endpackage

// ===== src/asq_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; no package dependencies.
module asq_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 129
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write on enable, read every cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/abelian_square_stream_detector.sv =====
// Top level of the abelian square stream detector over a three-letter alphabet.
// Depends on asq_pkg and asq_ram (two copies of the prefix count ring).
//
// Usage:
//   Requests arrive on req_valid / req_stall / req_payload (symbol, restart).
//   A request is taken at a clock edge with req_valid high and req_stall low.
//   Each request yields exactly one response on rsp_valid / rsp_stall /
//   rsp_payload (square_ends_here, square_period, word_has_square).
//   csr_wr_en / csr_wr_data write max_period; write it only while idle.
//   Timing: one request is in work at a time. A letter takes an update
//   step, then a scan over the periods with a compare behind each issue,
//   then a load of the output register. The scan checks periods from 2
//   up to min(max_period, MAX_PERIOD_LIMIT) and len/2, and stops at the
//   first match. Symbol 3 skips update and scan and goes to the load.
//   The scan rate is one pair of ring reads (p and 2p back) a cycle.
//   The output register holds a finished response while rsp_stall is high;
//   the next request is already accepted, but its result waits until the
//   register is free.
//   Reset: clears counts, length, sticky flag, ring head and max_period
//   (to 40), and writes a zero prefix to ring slot 0. No clearing pass.
module abelian_square_stream_detector #(
   parameter int MAX_PERIOD_LIMIT = asq_pkg::MAX_PERIOD_LIMIT_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  asq_pkg::req_payload_type   req_payload,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output asq_pkg::rsp_payload_type   rsp_payload,
   input  logic                       csr_wr_en,
   input  logic [asq_pkg::PERIOD_W-1:0] csr_wr_data
);

   localparam int DEPTH   = 2 * MAX_PERIOD_LIMIT + 1;
   localparam int AW      = $clog2(DEPTH);
   localparam int LEN_CAP = 2 * MAX_PERIOD_LIMIT;
   localparam int LW      = $clog2(LEN_CAP + 1);
   localparam int PW      = $clog2(MAX_PERIOD_LIMIT + 2);
   localparam int CW      = asq_pkg::COUNT_W;
   localparam int LNW     = asq_pkg::LANE_W;

   asq_pkg::state_type state_ff, state_in;

   logic [asq_pkg::SYMBOL_W-1:0] sym_ff, sym_in;
   logic [CW-1:0]       counts_ff, counts_in, counts_next;
   logic [LW-1:0]       len_ff, len_in;
   logic                found_ff, found_in;
   logic [AW-1:0]       head_ff, head_in, head_next;
   logic [PW-1:0]       p_ff, p_in;
   logic                cmp_valid_ff, cmp_valid_in;
   logic [PW-1:0]       cmp_p_ff, cmp_p_in;
   logic                hit_ff, hit_in;
   logic [PW-1:0]       period_ff, period_in;
   logic [asq_pkg::PERIOD_W-1:0] max_period_ff;
   logic                rsp_valid_ff, rsp_valid_in;
   asq_pkg::rsp_payload_type rsp_payload_ff, rsp_payload_in;

   logic                accept;
   logic                rsp_load;
   logic [PW-1:0]       limit;
   logic                issue_ok;
   logic                halves_eq;
   logic                ram_wr_en;
   logic [AW-1:0]       ram_wr_addr;
   logic [CW-1:0]       ram_wr_data;
   logic [AW-1:0]       rd_addr_mid, rd_addr_old;
   logic [CW-1:0]       rd_mid, rd_old;

   // Ring slot that lies span entries behind head
   function automatic logic [AW-1:0] back_addr(input logic [AW-1:0] head,
                                               input logic [AW:0]   span);
      logic [AW:0] diff;
      diff = {1'b0, head} - span;
      if (diff[AW]) begin
         diff = diff + (AW+1)'(DEPTH);
      end
      return diff[AW-1:0];
   endfunction

   // Both halves hold the same letter counts, lane by lane modulo 256
   function automatic logic halves_equal(input logic [CW-1:0] newest,
                                         input logic [CW-1:0] mid,
                                         input logic [CW-1:0] oldest);
      logic eq;
      eq = 1'b1;
      for (int lane = 0; lane < asq_pkg::NUM_LANES; lane++) begin
         if ((newest[lane*LNW +: LNW] - mid[lane*LNW +: LNW]) !=
             (mid[lane*LNW +: LNW] - oldest[lane*LNW +: LNW])) begin
            eq = 1'b0;
         end
      end
      return eq;
   endfunction

   // Ring copies: one read for the middle prefix, one for the oldest
   asq_ram #(.WIDTH(CW), .DEPTH(DEPTH)) u_ring_mid (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (rd_addr_mid),
      .rd_data (rd_mid)
   );

   asq_ram #(.WIDTH(CW), .DEPTH(DEPTH)) u_ring_old (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (rd_addr_old),
      .rd_data (rd_old)
   );

   // Scan helpers: effective limit, period issue check, read addresses
   always_comb begin
      if (int'(max_period_ff) > MAX_PERIOD_LIMIT) begin
         limit = PW'(MAX_PERIOD_LIMIT);
      end else begin
         limit = PW'(max_period_ff);
      end
      issue_ok    = (p_ff <= limit) && (int'(p_ff) <= int'(len_ff >> 1));
      rd_addr_mid = back_addr(head_ff, (AW+1)'(p_ff));
      rd_addr_old = back_addr(head_ff, (AW+1)'({p_ff, 1'b0}));
      halves_eq   = halves_equal(counts_ff, rd_mid, rd_old);
   end

   // Advance the counts and ring head for a new letter
   always_comb begin
      counts_next = counts_ff;
      for (int lane = 0; lane < asq_pkg::NUM_LANES; lane++) begin
         if (int'(sym_ff) == lane) begin
            counts_next[lane*LNW +: LNW] = counts_ff[lane*LNW +: LNW] + LNW'(1);
         end
      end
      if (int'(head_ff) == DEPTH - 1) begin
         head_next = '0;
      end else begin
         head_next = head_ff + AW'(1);
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         asq_pkg::ST_IDLE: begin
            if (req_valid) begin
               if (req_payload.symbol == asq_pkg::SYM_NONE) begin
                  state_in = asq_pkg::ST_FINISH;
               end else begin
                  state_in = asq_pkg::ST_UPDATE;
               end
            end
         end
         asq_pkg::ST_UPDATE: begin
            state_in = asq_pkg::ST_SCAN;
         end
         asq_pkg::ST_SCAN: begin
            if ((cmp_valid_ff && halves_eq) || !issue_ok) begin
               state_in = asq_pkg::ST_FINISH;
            end
         end
         asq_pkg::ST_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               state_in = asq_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = asq_pkg::ST_IDLE;
         end
      endcase
   end

   // Handshake and ring write controls
   always_comb begin
      accept      = 1'b0;
      rsp_load    = 1'b0;
      ram_wr_en   = 1'b0;
      ram_wr_addr = head_ff;
      ram_wr_data = '0;
      case (state_ff)
         asq_pkg::ST_IDLE: begin
            accept    = req_valid;
            ram_wr_en = req_valid && req_payload.restart;
         end
         asq_pkg::ST_UPDATE: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = head_next;
            ram_wr_data = counts_next;
         end
         asq_pkg::ST_FINISH: begin
            rsp_load = !rsp_valid_ff || !rsp_stall;
         end
         default: begin
         end
      endcase
      // Seed slot 0 with the empty prefix during reset
      if (reset) begin
         ram_wr_en   = 1'b1;
         ram_wr_addr = '0;
         ram_wr_data = '0;
      end
   end

   assign req_stall = (state_ff != asq_pkg::ST_IDLE);

   // Datapath next values
   always_comb begin
      sym_in       = sym_ff;
      counts_in    = counts_ff;
      len_in       = len_ff;
      found_in     = found_ff;
      head_in      = head_ff;
      p_in         = p_ff;
      cmp_valid_in = cmp_valid_ff;
      cmp_p_in     = cmp_p_ff;
      hit_in       = hit_ff;
      period_in    = period_ff;

      // Take the request; restart clears the word history
      if (accept) begin
         sym_in    = req_payload.symbol;
         hit_in    = 1'b0;
         period_in = '0;
         if (req_payload.restart) begin
            counts_in = '0;
            len_in    = '0;
            found_in  = 1'b0;
         end
      end

      // Commit the letter and prime the scan
      if (state_ff == asq_pkg::ST_UPDATE) begin
         counts_in    = counts_next;
         head_in      = head_next;
         if (int'(len_ff) < LEN_CAP) begin
            len_in = len_ff + LW'(1);
         end
         p_in         = PW'(asq_pkg::FIRST_PERIOD);
         cmp_valid_in = 1'b0;
      end

      // Issue one period per cycle, compare the one issued before
      if (state_ff == asq_pkg::ST_SCAN) begin
         cmp_valid_in = issue_ok;
         cmp_p_in     = p_ff;
         if (issue_ok) begin
            p_in = p_ff + PW'(1);
         end
         if (cmp_valid_ff && halves_eq) begin
            hit_in    = 1'b1;
            period_in = cmp_p_ff;
            found_in  = 1'b1;
         end
      end
   end

   // Output register
   always_comb begin
      rsp_valid_in   = rsp_valid_ff;
      rsp_payload_in = rsp_payload_ff;
      if (rsp_load) begin
         rsp_valid_in                    = 1'b1;
         rsp_payload_in.square_ends_here = hit_ff;
         rsp_payload_in.square_period    = asq_pkg::PERIOD_W'(period_ff);
         rsp_payload_in.word_has_square  = found_ff;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= asq_pkg::ST_IDLE;
         counts_ff     <= '0;
         len_ff        <= '0;
         found_ff      <= 1'b0;
         head_ff       <= '0;
         cmp_valid_ff  <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         max_period_ff <= asq_pkg::MAX_PERIOD_RESET;
      end else begin
         state_ff     <= state_in;
         counts_ff    <= counts_in;
         len_ff       <= len_in;
         found_ff     <= found_in;
         head_ff      <= head_in;
         cmp_valid_ff <= cmp_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            max_period_ff <= csr_wr_data;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      sym_ff         <= sym_in;
      p_ff           <= p_in;
      cmp_p_ff       <= cmp_p_in;
      hit_ff         <= hit_in;
      period_ff      <= period_in;
      rsp_payload_ff <= rsp_payload_in;
   end

endmodule

// ===== src/asq_checker.sv =====
// Port-level checks for the abelian square stream detector.
// Depends on asq_pkg; bound to the top level at the end of this file.
module asq_checker (
   input logic                     clock,
   input logic                     reset,
   input logic                     req_valid,
   input logic                     req_stall,
   input asq_pkg::req_payload_type req_payload,
   input logic                     rsp_valid,
   input logic                     rsp_stall,
   input asq_pkg::rsp_payload_type rsp_payload
);

   // Hold a stalled response
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload))
      else $error("stalled response changed");

   // Work on one request at a time
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request accepted while another is in work");

   // A miss carries no period
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_payload.square_ends_here |-> rsp_payload.square_period == '0)
      else $error("period reported without a square");

   // A hit sets the sticky word flag
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.square_ends_here |-> rsp_payload.word_has_square)
      else $error("square found but word flag clear");

endmodule

bind abelian_square_stream_detector asq_checker u_asq_checker (.*);
